### sv/tuple_key_hash_core_defines.svh
// Assertion macros for the tuple key hash block.
// Used by the checker module; no other dependencies.
`ifndef TUPLE_KEY_HASH_CORE_DEFINES_SVH
`define TUPLE_KEY_HASH_CORE_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define TKH_ASSERT_CLK(label, clock, resetn, prop) \
    label: assert property (@(posedge clock) disable iff (!resetn) prop) \
        else $error("tuple key hash check failed");

// Same, on the default clk / rst_n names of the enclosing scope.
`define TKH_ASSERT(label, prop) \
    `TKH_ASSERT_CLK(label, clk, rst_n, prop)

`endif

### sv/tkh_pkg.sv
// Types and constants shared by the tuple key hash block.
// No dependencies.
package tkh_pkg;

    localparam int NUM_FIELDS = 5;
    localparam int IN_W       = 32;
    localparam int LEN_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    localparam logic [31:0] MA_BASIS = 32'd5381;

    typedef logic [LEN_W-1:0] len_t;

    typedef enum logic [1:0] {
        HASH_MULADD = 2'd0,
        HASH_ELF    = 2'd1,
        HASH_KNUTH  = 2'd2
    } hash_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_HASH_KIND     = 3'd0,
        IDX_SKIP          = 3'd1,
        IDX_LEN_SRC_ADDR  = 3'd2,
        IDX_LEN_DST_ADDR  = 3'd3,
        IDX_LEN_SRC_PORT  = 3'd4,
        IDX_LEN_DST_PORT  = 3'd5,
        IDX_LEN_PROTOCOL  = 3'd6
    } cfg_idx_t;

    localparam len_t SKIP_THRESH [NUM_FIELDS] = '{6'd0, 6'd0, 6'd16, 6'd16, 6'd24};
    localparam len_t LEN_RESET = 6'd32;

    typedef struct packed {
        hash_kind_t                  kind;
        logic                        skip;
        len_t [NUM_FIELDS-1:0]       len;
    } cfg_t;

endpackage

### sv/tkh_if.sv
// Handshake interfaces for header transactions and hash key transactions.
// Depends on tkh_pkg.
interface tkh_hdr_if;
    logic                     valid;
    logic                     ready;
    logic [tkh_pkg::IN_W-1:0] src_addr;
    logic [tkh_pkg::IN_W-1:0] dst_addr;
    logic [tkh_pkg::IN_W-1:0] src_port;
    logic [tkh_pkg::IN_W-1:0] dst_port;
    logic [tkh_pkg::IN_W-1:0] protocol;

    modport source (output valid, src_addr, dst_addr, src_port, dst_port, protocol,
                    input ready);
    modport sink (input valid, src_addr, dst_addr, src_port, dst_port, protocol,
                  output ready);
endinterface

interface tkh_key_if;
    logic                     valid;
    logic                     ready;
    logic [tkh_pkg::IN_W-1:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink (input valid, hash_value, output ready);
endinterface

### sv/tkh_cfg_regs.sv
// Configuration register file: hash kind, skip enable, five prefix lengths.
// Depends on tkh_pkg.
module tkh_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tkh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tkh_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output tkh_pkg::cfg_t                    cfg
);

    tkh_pkg::cfg_t cfg_reg;
    tkh_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (tkh_pkg::cfg_idx_t'(cfg_index))
                tkh_pkg::IDX_HASH_KIND:    cfg_next.kind   = tkh_pkg::hash_kind_t'(cfg_wdata[1:0]);
                tkh_pkg::IDX_SKIP:         cfg_next.skip   = cfg_wdata[0];
                tkh_pkg::IDX_LEN_SRC_ADDR: cfg_next.len[0] = cfg_wdata[tkh_pkg::LEN_W-1:0];
                tkh_pkg::IDX_LEN_DST_ADDR: cfg_next.len[1] = cfg_wdata[tkh_pkg::LEN_W-1:0];
                tkh_pkg::IDX_LEN_SRC_PORT: cfg_next.len[2] = cfg_wdata[tkh_pkg::LEN_W-1:0];
                tkh_pkg::IDX_LEN_DST_PORT: cfg_next.len[3] = cfg_wdata[tkh_pkg::LEN_W-1:0];
                tkh_pkg::IDX_LEN_PROTOCOL: cfg_next.len[4] = cfg_wdata[tkh_pkg::LEN_W-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kind <= tkh_pkg::HASH_MULADD;
            cfg_reg.skip <= 1'b1;
            for (int i = 0; i < tkh_pkg::NUM_FIELDS; i++)
            begin
                cfg_reg.len[i] <= tkh_pkg::LEN_RESET;
            end
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/tkh_mask_stage.sv
// First pipeline stage: prefix masking, field selection and hash start value.
// Depends on tkh_pkg.
module tkh_mask_stage #(
    parameter int FW = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tkh_pkg::cfg_t            cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [tkh_pkg::IN_W-1:0] in_words [tkh_pkg::NUM_FIELDS],
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [FW-1:0]            out_words [tkh_pkg::NUM_FIELDS],
    output logic [tkh_pkg::NUM_FIELDS-1:0] out_sel,
    output logic [FW-1:0]            out_h
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [FW-1:0]                  words_reg [tkh_pkg::NUM_FIELDS];
    logic [FW-1:0]                  words_next [tkh_pkg::NUM_FIELDS];
    logic [tkh_pkg::NUM_FIELDS-1:0] sel_reg;
    logic [tkh_pkg::NUM_FIELDS-1:0] sel_next;
    logic [FW-1:0]                  h_reg;
    logic [FW-1:0]                  h_next;
    logic                           load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        logic [FW-1:0] pmask;
        pmask = '0;
        valid_next = load ? 1'b1 : (valid_reg && !out_ready);
        for (int i = 0; i < tkh_pkg::NUM_FIELDS; i++)
        begin
            if (int'(cfg.len[i]) >= FW)
                pmask = '1;
            else
                pmask = ~({FW{1'b1}} >> cfg.len[i]);
            words_next[i] = FW'(in_words[i]) & pmask;
            sel_next[i]   = !(cfg.skip && (cfg.len[i] <= tkh_pkg::SKIP_THRESH[i]));
        end
        if (cfg.kind == tkh_pkg::HASH_ELF || cfg.kind == tkh_pkg::HASH_KNUTH)
            h_next = '0;
        else
            h_next = FW'(tkh_pkg::MA_BASIS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            words_reg <= words_next;
            sel_reg   <= sel_next;
            h_reg     <= h_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_words = words_reg;
    assign out_sel   = sel_reg;
    assign out_h     = h_reg;

endmodule

### sv/tkh_fold_stage.sv
// Hash fold stage: folds the selected fields among FIRST..LAST into the running hash, one register stage.
// Depends on tkh_pkg.
module tkh_fold_stage #(
    parameter int FW    = 32,
    parameter int FIRST = 0,
    parameter int LAST  = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tkh_pkg::hash_kind_t            kind,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [FW-1:0]                  in_words [tkh_pkg::NUM_FIELDS],
    input  logic [tkh_pkg::NUM_FIELDS-1:0] in_sel,
    input  logic [FW-1:0]                  in_h,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [FW-1:0]                  out_words [tkh_pkg::NUM_FIELDS],
    output logic [tkh_pkg::NUM_FIELDS-1:0] out_sel,
    output logic [FW-1:0]                  out_h
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [FW-1:0]                  words_reg [tkh_pkg::NUM_FIELDS];
    logic [tkh_pkg::NUM_FIELDS-1:0] sel_reg;
    logic [FW-1:0]                  h_reg;
    logic [FW-1:0]                  h_next;
    logic                           load;

    function automatic logic [FW-1:0] fold(tkh_pkg::hash_kind_t k, logic [FW-1:0] h,
                                           logic [FW-1:0] w);
        logic [FW-1:0] t;
        logic [FW-1:0] high;
        t    = '0;
        high = '0;
        case (k)
            tkh_pkg::HASH_ELF:
            begin
                t    = (h << 4) + w;
                high = {t[FW-1:FW-4], {(FW-4){1'b0}}};
                t    = (t ^ (high >> (FW - 8))) & ~high;
            end
            tkh_pkg::HASH_KNUTH:
                t = {h[FW-6:0], h[FW-1:FW-5]} ^ w;
            default:
                t = (h << 5) + h + w;
        endcase
        return t;
    endfunction

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = load ? 1'b1 : (valid_reg && !out_ready);
        h_next     = in_h;
        for (int i = FIRST; i <= LAST; i++)
        begin
            if (in_sel[i])
                h_next = fold(kind, h_next, in_words[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            words_reg <= in_words;
            sel_reg   <= in_sel;
            h_reg     <= h_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_words = words_reg;
    assign out_sel   = sel_reg;
    assign out_h     = h_reg;

endmodule

### sv/tuple_key_hash_core.sv
// Top level of the tuple key hash block: config registers and three-stage hash pipeline.
// Depends on tkh_pkg, tkh_if, tkh_cfg_regs, tkh_mask_stage, tkh_fold_stage.
//
//  port        role      payload
//  ----------  --------  ------------------------------------------------------
//  hdr         sink      src_addr, dst_addr, src_port, dst_port, protocol
//  key         source    hash_value
//  cfg_*       write     cfg_index selects register, cfg_wdata holds value
//
// One transaction per cycle while key.ready is high; each header passes every stage.
// Stages: prefix mask and select, fold fields 0..2, fold fields 3..4 (output register).
// Ready propagates back through the stage valid bits; a stall holds only full stages.
// Reset clears all stage valid bits and loads register defaults; no clearing pass.
module tuple_key_hash_core #(
    parameter int FIELD_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tkh_hdr_if.sink                         hdr,
    tkh_key_if.source                       key,
    input  logic                            cfg_we,
    input  logic [tkh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tkh_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    tkh_pkg::cfg_t                  cfg;
    logic [tkh_pkg::IN_W-1:0]       hdr_words [tkh_pkg::NUM_FIELDS];

    logic                           s1_valid, s1_ready;
    logic [FIELD_WIDTH-1:0]         s1_words [tkh_pkg::NUM_FIELDS];
    logic [tkh_pkg::NUM_FIELDS-1:0] s1_sel;
    logic [FIELD_WIDTH-1:0]         s1_h;

    logic                           s2_valid, s2_ready;
    logic [FIELD_WIDTH-1:0]         s2_words [tkh_pkg::NUM_FIELDS];
    logic [tkh_pkg::NUM_FIELDS-1:0] s2_sel;
    logic [FIELD_WIDTH-1:0]         s2_h;

    logic [FIELD_WIDTH-1:0]         s3_words [tkh_pkg::NUM_FIELDS];
    logic [tkh_pkg::NUM_FIELDS-1:0] s3_sel;
    logic [FIELD_WIDTH-1:0]         s3_h;

    assign hdr_words[0] = hdr.src_addr;
    assign hdr_words[1] = hdr.dst_addr;
    assign hdr_words[2] = hdr.src_port;
    assign hdr_words[3] = hdr.dst_port;
    assign hdr_words[4] = hdr.protocol;

    tkh_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tkh_mask_stage #(.FW(FIELD_WIDTH)) u_mask (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (hdr.valid),
        .in_ready  (hdr.ready),
        .in_words  (hdr_words),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_words (s1_words),
        .out_sel   (s1_sel),
        .out_h     (s1_h)
    );

    tkh_fold_stage #(.FW(FIELD_WIDTH), .FIRST(0), .LAST(2)) u_fold_lo (
        .clk       (clk),
        .rst_n     (rst_n),
        .kind      (cfg.kind),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_words  (s1_words),
        .in_sel    (s1_sel),
        .in_h      (s1_h),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_words (s2_words),
        .out_sel   (s2_sel),
        .out_h     (s2_h)
    );

    tkh_fold_stage #(.FW(FIELD_WIDTH), .FIRST(3), .LAST(4)) u_fold_hi (
        .clk       (clk),
        .rst_n     (rst_n),
        .kind      (cfg.kind),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_words  (s2_words),
        .in_sel    (s2_sel),
        .in_h      (s2_h),
        .out_valid (key.valid),
        .out_ready (key.ready),
        .out_words (s3_words),
        .out_sel   (s3_sel),
        .out_h     (s3_h)
    );

    assign key.hash_value = tkh_pkg::IN_W'(s3_h);

endmodule

### sv/tkh_checker.sv
// Port-level checker for tuple_key_hash_core, attached by bind.
// Depends on tuple_key_hash_core_defines.svh.
`include "tuple_key_hash_core_defines.svh"

module tkh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        hdr_valid,
    input logic        hdr_ready,
    input logic        key_valid,
    input logic        key_ready,
    input logic [31:0] key_hash_value
);

    // stalled key transaction holds
    `TKH_ASSERT(a_key_hold, key_valid && !key_ready |=> key_valid && $stable(key_hash_value))

    // backpressure only comes from a stalled output
    `TKH_ASSERT(a_bp_src, !hdr_ready |-> key_valid && !key_ready)

    // an empty output fills only from a header accept that passed the mask, fold_lo and fold_hi registers unstalled
    `TKH_ASSERT(a_latency, $rose(key_valid) |-> $past(hdr_valid && hdr_ready, 3))

endmodule

bind tuple_key_hash_core tkh_checker u_tkh_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .hdr_valid      (hdr.valid),
    .hdr_ready      (hdr.ready),
    .key_valid      (key.valid),
    .key_ready      (key.ready),
    .key_hash_value (key.hash_value)
);

### tb/tuple_key_hash_core_checker.sv
`timescale 1ns / 100ps
// Scoreboard for tuple_key_hash_core: mirrors the config registers, predicts the key
// of every accepted header and compares it with each accepted key transaction.
// Depends on tkh_pkg and tkh_if.
module tuple_key_hash_core_checker
    import tkh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    tkh_hdr_if                    hdr,
    tkh_key_if                    key,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending,
    output int                    keys_checked
);

    logic [1:0]      kind_q;
    logic            skip_q;
    len_t            len_q [NUM_FIELDS];
    logic [IN_W-1:0] expected_keys [$];
    int              fails;
    int              checked;

    function automatic logic [IN_W-1:0] tuple_key(input logic [IN_W-1:0] words [NUM_FIELDS]);
        logic [IN_W-1:0] h;
        logic [IN_W-1:0] w;
        logic [IN_W-1:0] mask;
        logic [IN_W-1:0] top;
        h = (kind_q == HASH_ELF || kind_q == HASH_KNUTH) ? '0 : MA_BASIS;
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            if (!(skip_q && len_q[i] <= SKIP_THRESH[i]))
            begin
                mask = (len_q[i] >= IN_W) ? '1 : ~({IN_W{1'b1}} >> len_q[i]);
                w = words[i] & mask;
                case (kind_q)
                    HASH_ELF:
                    begin
                        h = (h << 4) + w;
                        top = h & 32'hF000_0000;
                        h = (h ^ (top >> 24)) & ~top;
                    end
                    HASH_KNUTH: h = {h[IN_W-6:0], h[IN_W-1:IN_W-5]} ^ w;
                    default:    h = h * 33 + w;   // kind 3 folds like multiply-add
                endcase
            end
        end
        return h;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [IN_W-1:0] words [NUM_FIELDS];
        logic [IN_W-1:0] want;
        if (!rst_n)
        begin
            kind_q = HASH_MULADD;
            skip_q = 1'b1;
            for (int i = 0; i < NUM_FIELDS; i++)
                len_q[i] = LEN_RESET;
            expected_keys.delete();
            fails = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    IDX_HASH_KIND: kind_q = cfg_wdata[1:0];
                    IDX_SKIP:      skip_q = cfg_wdata[0];
                    IDX_LEN_SRC_ADDR, IDX_LEN_DST_ADDR, IDX_LEN_SRC_PORT,
                    IDX_LEN_DST_PORT, IDX_LEN_PROTOCOL:
                        len_q[cfg_index - IDX_LEN_SRC_ADDR] = cfg_wdata;
                    default: ;
                endcase
            end
            if (hdr.valid && hdr.ready)
            begin
                words = '{hdr.src_addr, hdr.dst_addr, hdr.src_port, hdr.dst_port,
                          hdr.protocol};
                expected_keys = {expected_keys, tuple_key(words)};
            end
            if (key.valid && key.ready)
            begin
                if (expected_keys.size() == 0)
                begin
                    fails++;
                    $error("hash_value: unexpected transaction, expected none, actual %h",
                           key.hash_value);
                end
                else
                begin
                    want = expected_keys.pop_front();
                    checked++;
                    if (key.hash_value !== want)
                    begin
                        fails++;
                        $error("hash_value mismatch: expected %h, actual %h",
                               want, key.hash_value);
                    end
                end
            end
        end
        fail_count   <= fails;
        pending      <= expected_keys.size();
        keys_checked <= checked;
    end

endmodule

### tb/tuple_key_hash_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for tuple_key_hash_core: clock, reset, config writes, header stimulus
// with idle and back-pressure phases, and the verdict.
// Depends on tkh_pkg, tkh_if, tuple_key_hash_core and tuple_key_hash_core_checker.
module tuple_key_hash_core_tb;
    import tkh_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int LONG_HOLD     = 64;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 135;

    localparam logic [1:0]           HASH_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED  = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int         fail_count;
    int         pending;
    int         keys_checked;
    idle_mode_t idle_mode = IDLE_NONE;
    int         hold_req = 0;
    int         headers_sent = 0;
    int         settings_used = 0;
    int         cycle_count;

    tkh_hdr_if hdr_ch ();
    tkh_key_if key_ch ();

    tuple_key_hash_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr       (hdr_ch),
        .key       (key_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    tuple_key_hash_core_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .hdr          (hdr_ch),
        .key          (key_ch),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .keys_checked (keys_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic int sender_pct(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER: return 52;
            IDLE_BOTH:   return 19;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_pct(input idle_mode_t mode);
        case (mode)
            IDLE_RECEIVER: return 52;
            IDLE_BOTH:     return 19;
            default:       return 0;
        endcase
    endfunction

    function automatic logic [1:0] kind_code(input int k);
        case (k % 4)
            0:       return HASH_MULADD;
            1:       return HASH_ELF;
            2:       return HASH_KNUTH;
            default: return HASH_UNUSED;
        endcase
    endfunction

    function automatic len_t pick_len(input int field);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SKIP_THRESH[field];
            2:       return len_t'(SKIP_THRESH[field] + 1);
            3:       return LEN_RESET;
            4:       return len_t'($urandom_range(33, 63));
            default: return len_t'($urandom_range(0, 32));
        endcase
    endfunction

    function automatic logic [IN_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // key channel ready: random stalls per phase, plus a long hold on request
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        key_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                key_ch.ready <= 1'b0;
            end
            else if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
                key_ch.ready <= 1'b0;
            end
            else
                key_ch.ready <= ($urandom_range(0, 99) >= receiver_pct(idle_mode));
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d keys outstanding", cycle_count, pending);
        $display("FAIL tuple_key_hash_core");
        $finish;
    end

    // returns at the edge where the header transaction is accepted
    task automatic send_header(input logic [IN_W-1:0] words [NUM_FIELDS]);
        int pct;
        pct = sender_pct(idle_mode);
        if (pct > 0 && $urandom_range(0, 99) < pct)
        begin
            hdr_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < pct);
        end
        hdr_ch.valid    <= 1'b1;
        hdr_ch.src_addr <= words[0];
        hdr_ch.dst_addr <= words[1];
        hdr_ch.src_port <= words[2];
        hdr_ch.dst_port <= words[3];
        hdr_ch.protocol <= words[4];
        do @(posedge clk); while (!hdr_ch.ready);
        headers_sent++;
    endtask

    task automatic send_words(input logic [IN_W-1:0] a, b, c, d, e);
        logic [IN_W-1:0] words [NUM_FIELDS];
        words = '{a, b, c, d, e};
        send_header(words);
    endtask

    task automatic send_random();
        logic [IN_W-1:0] words [NUM_FIELDS];
        for (int i = 0; i < NUM_FIELDS; i++)
            words[i] = rand_word();
        send_header(words);
    endtask

    task automatic wait_for_keys();
        hdr_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(posedge clk);
    endtask

    // only called with the pipeline empty
    task automatic apply_setting(input logic [1:0] kind, input logic skip,
                                 input len_t lens [NUM_FIELDS]);
        write_reg(IDX_UNUSED, CFG_DATA_W'($urandom));
        write_reg(IDX_HASH_KIND, {4'($urandom), kind});
        write_reg(IDX_SKIP, {5'($urandom), skip});
        for (int i = 0; i < NUM_FIELDS; i++)
            write_reg(CFG_IDX_W'(IDX_LEN_SRC_ADDR + i), lens[i]);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        len_t lens [NUM_FIELDS];
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_wdata       <= '0;
        hdr_ch.valid    <= 1'b0;
        hdr_ch.src_addr <= '0;
        hdr_ch.dst_addr <= '0;
        hdr_ch.src_port <= '0;
        hdr_ch.dst_port <= '0;
        hdr_ch.protocol <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: multiply-add, skipping on, full prefixes
        send_words('0, '0, '0, '0, '0);
        send_words('1, '1, '1, '1, '1);
        send_words(32'h8000_0001, 32'h7FFF_FFFE, 32'h0000_FFFF, 32'hFFFF_0000, 32'hAAAA_5555);
        send_random();

        // zero prefixes with skipping off still fold zero words
        wait_for_keys();
        lens = '{default: '0};
        apply_setting(HASH_ELF, 1'b0, lens);
        send_words('1, '1, '1, '1, '1);
        send_random();

        // every field at its threshold: nothing selected, start value comes out
        wait_for_keys();
        apply_setting(HASH_MULADD, 1'b1, SKIP_THRESH);
        send_words('1, '1, '1, '1, '1);
        send_random();
        wait_for_keys();
        apply_setting(HASH_KNUTH, 1'b1, SKIP_THRESH);
        send_words('1, '1, '1, '1, '1);

        // unused kind code with prefixes past the word width
        wait_for_keys();
        lens = '{default: 6'd63};
        apply_setting(HASH_UNUSED, 1'b0, lens);
        send_words('1, '1, '1, '1, '1);
        send_random();
        send_random();

        wait_for_keys();
        lens = '{default: LEN_RESET};
        apply_setting(HASH_KNUTH, 1'b0, lens);
        send_words('1, '1, '1, '1, '1);
        send_random();
        send_words('0, '0, '0, '0, '0);

        // just above threshold; ELF top nibble folding
        wait_for_keys();
        for (int i = 0; i < NUM_FIELDS; i++)
            lens[i] = len_t'(SKIP_THRESH[i] + 1);
        apply_setting(HASH_ELF, 1'b1, lens);
        send_words('1, '1, '1, '1, '1);
        send_words(32'hF000_0000, 32'hF000_0000, 32'hF000_0000, 32'hF000_0000,
                   32'hF000_0000);
        send_random();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_for_keys();
            for (int i = 0; i < NUM_FIELDS; i++)
                lens[i] = pick_len(i);
            apply_setting(kind_code(p), 1'($urandom_range(0, 1)), lens);
            idle_mode <= idle_mode_t'((p / 2) % 4);
            if (p % 3 == 2)
                hold_req <= hold_req + 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p % 2 == 1 && n == PHASE_ITEMS / 2)
                    wait_for_keys();
                send_random();
            end
        end

        wait_for_keys();
        repeat (10) @(posedge clk);
        $display("Checked %0d keys from %0d headers over %0d register settings",
                 keys_checked, headers_sent, settings_used);
        $display("  covering all four kind codes, zero, threshold and saturated prefixes");
        if (fail_count == 0 && pending == 0)
            $display("PASS tuple_key_hash_core");
        else
            $display("FAIL tuple_key_hash_core");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/tkh_pkg.sv
sv/tkh_if.sv
sv/tkh_cfg_regs.sv
sv/tkh_mask_stage.sv
sv/tkh_fold_stage.sv
sv/tuple_key_hash_core.sv
sv/tkh_checker.sv
tb/tuple_key_hash_core_checker.sv
tb/tuple_key_hash_core_tb.sv
